@@ src/qra_pkg.sv @@
// Types, constants and table functions shared by the quaternion rotation
// accumulator modules. No dependencies.
package qra_pkg;

    localparam int CW = 36;          // CORDIC datapath width
    localparam int HW = 34;          // reduced half angle width, Q30

    localparam logic signed [63:0] GAIN_Q30    = 64'sd652032874;
    localparam logic signed [63:0] PI_Q30      = 64'sd3373259426;
    localparam logic signed [63:0] HALF_PI_Q30 = 64'sd1686629713;

    typedef struct packed {
        logic signed [15:0] axis_x;
        logic signed [15:0] axis_y;
        logic signed [15:0] axis_z;
        logic signed [15:0] angle;
    } in_t;

    typedef struct packed {
        logic signed [15:0] m00;
        logic signed [15:0] m01;
        logic signed [15:0] m02;
        logic signed [15:0] m10;
        logic signed [15:0] m11;
        logic signed [15:0] m12;
        logic signed [15:0] m20;
        logic signed [15:0] m21;
        logic signed [15:0] m22;
        logic               degenerate;
    } out_t;

    typedef struct packed {
        logic signed [15:0]   axis_x;
        logic signed [15:0]   axis_y;
        logic signed [15:0]   axis_z;
        logic signed [HW-1:0] half_angle;
        logic                 flip;
    } work_t;

    typedef struct packed {
        logic               start;
        logic signed [63:0] op_a;
        logic signed [63:0] op_b;
    } mul_req_t;

    typedef struct packed {
        logic               done;
        logic signed [63:0] prod;
    } mul_rsp_t;

    typedef struct packed {
        logic [1:0] a;
        logic [1:0] b;
        logic [1:0] c;
        logic       neg;
    } ham_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_CORDIC,
        BK_AXIS,
        BK_HAM,
        BK_SQ,
        BK_SQRT,
        BK_NORM,
        BK_DIV_SETUP,
        BK_DIV,
        BK_DIV_END,
        BK_MAT,
        BK_OUT
    } back_state_t;

    function automatic logic [31:0] atan_q30(input logic [4:0] i);
        case (i)
            5'd0:    return 32'd843314857;
            5'd1:    return 32'd497837829;
            5'd2:    return 32'd263043837;
            5'd3:    return 32'd133525159;
            5'd4:    return 32'd67021687;
            5'd5:    return 32'd33543516;
            5'd6:    return 32'd16775851;
            5'd7:    return 32'd8388437;
            5'd8:    return 32'd4194283;
            5'd9:    return 32'd2097149;
            5'd10:   return 32'd1048576;
            5'd11:   return 32'd524288;
            5'd12:   return 32'd262144;
            5'd13:   return 32'd131072;
            5'd14:   return 32'd65536;
            5'd15:   return 32'd32768;
            5'd16:   return 32'd16384;
            5'd17:   return 32'd8192;
            5'd18:   return 32'd4096;
            5'd19:   return 32'd2048;
            5'd20:   return 32'd1024;
            5'd21:   return 32'd512;
            5'd22:   return 32'd256;
            5'd23:   return 32'd128;
            default: return 32'd0;
        endcase
    endfunction

    // Hamilton product schedule: c[c] (+/-)= a[a] * b[b]
    function automatic ham_t ham_entry(input logic [3:0] j);
        case (j)
            4'd0:    return '{a: 2'd0, b: 2'd0, c: 2'd0, neg: 1'b0};
            4'd1:    return '{a: 2'd1, b: 2'd1, c: 2'd0, neg: 1'b1};
            4'd2:    return '{a: 2'd2, b: 2'd2, c: 2'd0, neg: 1'b1};
            4'd3:    return '{a: 2'd3, b: 2'd3, c: 2'd0, neg: 1'b1};
            4'd4:    return '{a: 2'd0, b: 2'd1, c: 2'd1, neg: 1'b0};
            4'd5:    return '{a: 2'd1, b: 2'd0, c: 2'd1, neg: 1'b0};
            4'd6:    return '{a: 2'd2, b: 2'd3, c: 2'd1, neg: 1'b0};
            4'd7:    return '{a: 2'd3, b: 2'd2, c: 2'd1, neg: 1'b1};
            4'd8:    return '{a: 2'd0, b: 2'd2, c: 2'd2, neg: 1'b0};
            4'd9:    return '{a: 2'd2, b: 2'd0, c: 2'd2, neg: 1'b0};
            4'd10:   return '{a: 2'd3, b: 2'd1, c: 2'd2, neg: 1'b0};
            4'd11:   return '{a: 2'd1, b: 2'd3, c: 2'd2, neg: 1'b1};
            4'd12:   return '{a: 2'd0, b: 2'd3, c: 2'd3, neg: 1'b0};
            4'd13:   return '{a: 2'd3, b: 2'd0, c: 2'd3, neg: 1'b0};
            4'd14:   return '{a: 2'd1, b: 2'd2, c: 2'd3, neg: 1'b0};
            4'd15:   return '{a: 2'd2, b: 2'd1, c: 2'd3, neg: 1'b1};
            default: return '{a: 2'd0, b: 2'd0, c: 2'd0, neg: 1'b0};
        endcase
    endfunction

    // Matrix products: yy zz xx xy zw xz yw yz xw (w=0 x=1 y=2 z=3)
    function automatic logic [3:0] mat_pair(input logic [3:0] j);
        case (j)
            4'd0:    return {2'd2, 2'd2};
            4'd1:    return {2'd3, 2'd3};
            4'd2:    return {2'd1, 2'd1};
            4'd3:    return {2'd1, 2'd2};
            4'd4:    return {2'd3, 2'd0};
            4'd5:    return {2'd1, 2'd3};
            4'd6:    return {2'd2, 2'd0};
            4'd7:    return {2'd2, 2'd3};
            4'd8:    return {2'd1, 2'd0};
            default: return {2'd0, 2'd0};
        endcase
    endfunction

    function automatic logic signed [63:0] rnd64(input logic signed [63:0] v,
                                                 input int unsigned s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
        if (v > 64'sd32767)
            return 16'sh7fff;
        if (v < -64'sd32768)
            return 16'sh8000;
        return v[15:0];
    endfunction

endpackage

@@ src/quaternion_rotation_accumulator_unit.sv @@
// Quaternion rotation accumulator: axis/angle in, rotation matrix out.
// New transactions are taken into the queue while the back end still works on an earlier one.
// A zero norm skips the divider. The back end's time is set by the shared multiplier
// (32 products), the 32-step square root and the 64-step divider run once per component.
// Reset: orientation is identity, the queue and output register are empty.
// Depends on qra_pkg, qra_front, qra_fifo, qra_mul, qra_back.
module quaternion_rotation_accumulator_unit #(
    parameter int CORDIC_STEPS = 16,
    parameter int FRAC_BITS    = 14
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    output logic           item_stall,
    input  qra_pkg::in_t   item,
    output logic           result_valid,
    input  logic           result_stall,
    output qra_pkg::out_t  result
);

    // front: accept transaction, form half angle, fold it into +/- a quarter turn
    logic               push;
    logic               full;
    qra_pkg::work_t     front_work;

    // queue: decouples intake from the long-running back end
    logic               q_pop;
    logic               q_nonempty;
    qra_pkg::work_t     q_data;

    // shared multiplier
    qra_pkg::mul_req_t  mul_req;
    qra_pkg::mul_rsp_t  mul_rsp;

    qra_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .push       (push),
        .full       (full),
        .work       (front_work)
    );

    qra_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .din      (front_work),
        .full     (full),
        .pop      (q_pop),
        .nonempty (q_nonempty),
        .dout     (q_data)
    );

    qra_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    // back: CORDIC, Hamilton product, norm, normalize, matrix, output register
    qra_back #(
        .CORDIC_STEPS (CORDIC_STEPS),
        .FRAC_BITS    (FRAC_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_nonempty   (q_nonempty),
        .q_data       (q_data),
        .q_pop        (q_pop),
        .mul_req      (mul_req),
        .mul_rsp      (mul_rsp),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

@@ src/qra_mul.sv @@
// Shared 64x64 multiplier, low 64 bits, one 32x32 partial product a cycle.
// Depends on qra_pkg.
module qra_mul (
    input  logic               clk,
    input  logic               rst_n,
    input  qra_pkg::mul_req_t  req,
    output qra_pkg::mul_rsp_t  rsp
);

    logic [63:0] a_reg;
    logic [63:0] b_reg;
    logic [63:0] pp_reg;
    logic [63:0] acc_reg;
    logic [1:0]  cnt_reg;
    logic        run_reg;
    logic        done_reg;

    logic [31:0] ma;
    logic [31:0] mb;
    logic [63:0] prod;

    assign ma   = (cnt_reg == 2'd2) ? a_reg[63:32] : a_reg[31:0];
    assign mb   = (cnt_reg == 2'd1) ? b_reg[63:32] : b_reg[31:0];
    assign prod = {32'd0, ma} * {32'd0, mb};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else if (req.start)
        begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else if (run_reg)
        begin
            cnt_reg  <= cnt_reg + 2'd1;
            run_reg  <= (cnt_reg != 2'd3);
            done_reg <= (cnt_reg == 2'd3);
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg   <= req.op_a;
            b_reg   <= req.op_b;
            acc_reg <= 64'd0;
        end
        else if (run_reg)
        begin
            if (cnt_reg == 2'd0)
                pp_reg <= prod;
            else
                pp_reg <= {prod[31:0], 32'd0};
            if (cnt_reg != 2'd0)
                acc_reg <= acc_reg + pp_reg;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.prod = acc_reg;

endmodule

@@ src/qra_front.sv @@
// Input stage: takes transactions, forms and range-reduces the half angle.
// Depends on qra_pkg.
module qra_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_stall,
    input  qra_pkg::in_t    item,
    output logic            push,
    input  logic            full,
    output qra_pkg::work_t  work
);

    localparam int HW = qra_pkg::HW;
    localparam logic signed [HW-1:0] HALF_PI = HW'(qra_pkg::HALF_PI_Q30);
    localparam logic signed [HW-1:0] PI      = HW'(qra_pkg::PI_Q30);

    logic           vld_reg;
    qra_pkg::work_t work_reg;
    qra_pkg::work_t work_next;
    logic signed [HW-1:0] h_raw;
    logic           accept;

    assign h_raw      = HW'(item.angle) <<< 17;
    assign push       = vld_reg && !full;
    assign item_stall = vld_reg && full;
    assign accept     = item_valid && !item_stall;
    assign work       = work_reg;

    always_comb
    begin
        work_next.axis_x = item.axis_x;
        work_next.axis_y = item.axis_y;
        work_next.axis_z = item.axis_z;
        if (h_raw > HALF_PI)
        begin
            work_next.half_angle = h_raw - PI;
            work_next.flip       = 1'b1;
        end
        else if (h_raw < -HALF_PI)
        begin
            work_next.half_angle = h_raw + PI;
            work_next.flip       = 1'b1;
        end
        else
        begin
            work_next.half_angle = h_raw;
            work_next.flip       = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (accept)
            vld_reg <= 1'b1;
        else if (push)
            vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            work_reg <= work_next;
    end

endmodule

@@ src/qra_fifo.sv @@
// Two-entry queue between front and back.
// Depends on qra_pkg.
module qra_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  qra_pkg::work_t  din,
    output logic            full,
    input  logic            pop,
    output logic            nonempty,
    output qra_pkg::work_t  dout
);

    qra_pkg::work_t mem_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;

    assign full     = (count_reg == 2'd2);
    assign nonempty = (count_reg != 2'd0);
    assign dout     = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= din;
    end

endmodule

@@ src/qra_back.sv @@
// Execution sequencer: CORDIC, quaternion product, norm, divide, matrix.
// Depends on qra_pkg; drives the shared qra_mul.
module qra_back #(
    parameter int CORDIC_STEPS = 16,
    parameter int FRAC_BITS    = 14
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_nonempty,
    input  qra_pkg::work_t     q_data,
    output logic               q_pop,
    output qra_pkg::mul_req_t  mul_req,
    input  qra_pkg::mul_rsp_t  mul_rsp,
    output logic               result_valid,
    input  logic               result_stall,
    output qra_pkg::out_t      result
);

    localparam int CW       = qra_pkg::CW;
    localparam int STEPS    = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
    localparam int SCALE_SH = 30 - FRAC_BITS;
    localparam logic signed [15:0] ONE_FIX =
        (FRAC_BITS >= 15) ? 16'sh7fff : 16'(64'sd1 <<< FRAC_BITS);
    localparam logic signed [63:0] ONE2 = 64'sd1 <<< (2 * FRAC_BITS);

    qra_pkg::back_state_t state_reg, state_next;

    logic [5:0]  cnt_reg;
    logic [3:0]  k_reg;
    logic        wait_reg;
    logic        result_valid_reg;
    logic signed [15:0] orient_reg [4];

    qra_pkg::work_t     work_reg;
    logic signed [CW-1:0] x_reg, y_reg, z_reg;
    logic signed [63:0] a_reg [4];
    logic signed [63:0] c_reg [4];
    logic [63:0]        rx_reg;
    logic [63:0]        rr_reg;
    logic [63:0]        divd_reg;
    logic [33:0]        rem_reg;
    logic               numneg_reg;
    logic               cneg_reg;
    logic signed [31:0] p_reg [9];
    logic               degen_reg;
    qra_pkg::out_t      result_reg;

    // CORDIC step
    logic               dir;
    logic signed [CW-1:0] xs, ys, nx, ny, nz, atan_w;
    logic               cordic_last;
    // multiplier handshake
    logic               mul_done;
    logic               mul_last;
    logic signed [63:0] prod;
    qra_pkg::ham_t      he;
    logic [3:0]         mp;
    logic signed [15:0] axis_sel;
    logic signed [63:0] sq_t;
    // square root step
    logic [63:0]        bitv;
    logic [63:0]        sq_sum;
    logic               sq_ge;
    // divide
    logic [33:0]        dvs;
    logic [34:0]        trial;
    logic [34:0]        diff;
    logic               tge;
    logic signed [63:0] ck, mag, num, unum, qv, vv;
    // output
    logic               can_load;
    logic signed [63:0] pe [9];
    qra_pkg::out_t      mat_w;

    assign dir         = !z_reg[CW-1];
    assign xs          = x_reg >>> cnt_reg[4:0];
    assign ys          = y_reg >>> cnt_reg[4:0];
    assign atan_w      = CW'({1'b0, qra_pkg::atan_q30(cnt_reg[4:0])});
    assign nx          = dir ? (x_reg - ys) : (x_reg + ys);
    assign ny          = dir ? (y_reg + xs) : (y_reg - xs);
    assign nz          = dir ? (z_reg - atan_w) : (z_reg + atan_w);
    assign cordic_last = (cnt_reg == 6'(STEPS - 1));

    assign mul_done = mul_rsp.done;
    assign prod     = mul_rsp.prod;
    assign he       = qra_pkg::ham_entry(k_reg);
    assign mp       = qra_pkg::mat_pair(k_reg);
    assign sq_t     = c_reg[k_reg[1:0]] >>> 2;

    always_comb
    begin
        case (k_reg[1:0])
            2'd0:    axis_sel = work_reg.axis_x;
            2'd1:    axis_sel = work_reg.axis_y;
            default: axis_sel = work_reg.axis_z;
        endcase
    end

    always_comb
    begin
        case (state_reg)
            qra_pkg::BK_AXIS: mul_last = (k_reg == 4'd2);
            qra_pkg::BK_HAM:  mul_last = (k_reg == 4'd15);
            qra_pkg::BK_SQ:   mul_last = (k_reg == 4'd3);
            qra_pkg::BK_MAT:  mul_last = (k_reg == 4'd8);
            default:          mul_last = 1'b0;
        endcase
    end

    assign bitv   = 64'd1 << (6'd62 - {cnt_reg[4:0], 1'b0});
    assign sq_sum = rr_reg + bitv;
    assign sq_ge  = (rx_reg >= sq_sum);

    assign dvs   = {rr_reg[31:0], 2'b00};
    assign trial = {rem_reg, divd_reg[63]};
    assign diff  = trial - {1'b0, dvs};
    assign tge   = (trial >= {1'b0, dvs});

    assign ck   = c_reg[k_reg[1:0]];
    assign mag  = ck[63] ? -ck : ck;
    assign num  = (mag <<< FRAC_BITS) + $signed({31'd0, dvs[33:1]});
    assign unum = num[63] ? -num : num;
    assign qv   = numneg_reg ? -$signed(divd_reg) : $signed(divd_reg);
    assign vv   = cneg_reg ? -qv : qv;

    assign can_load = !result_valid_reg || !result_stall;

    always_comb
    begin
        for (int i = 0; i < 9; i++)
            pe[i] = 64'(p_reg[i]);
        mat_w.m00 = qra_pkg::sat16(qra_pkg::rnd64(ONE2 - ((pe[0] + pe[1]) <<< 1), FRAC_BITS));
        mat_w.m01 = qra_pkg::sat16(qra_pkg::rnd64((pe[3] - pe[4]) <<< 1, FRAC_BITS));
        mat_w.m02 = qra_pkg::sat16(qra_pkg::rnd64((pe[5] + pe[6]) <<< 1, FRAC_BITS));
        mat_w.m10 = qra_pkg::sat16(qra_pkg::rnd64((pe[3] + pe[4]) <<< 1, FRAC_BITS));
        mat_w.m11 = qra_pkg::sat16(qra_pkg::rnd64(ONE2 - ((pe[2] + pe[1]) <<< 1), FRAC_BITS));
        mat_w.m12 = qra_pkg::sat16(qra_pkg::rnd64((pe[7] - pe[8]) <<< 1, FRAC_BITS));
        mat_w.m20 = qra_pkg::sat16(qra_pkg::rnd64((pe[5] - pe[6]) <<< 1, FRAC_BITS));
        mat_w.m21 = qra_pkg::sat16(qra_pkg::rnd64((pe[7] + pe[8]) <<< 1, FRAC_BITS));
        mat_w.m22 = qra_pkg::sat16(qra_pkg::rnd64(ONE2 - ((pe[2] + pe[0]) <<< 1), FRAC_BITS));
        mat_w.degenerate = degen_reg;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            qra_pkg::BK_IDLE:
                if (q_nonempty)
                    state_next = qra_pkg::BK_CORDIC;
            qra_pkg::BK_CORDIC:
                if (cordic_last)
                    state_next = qra_pkg::BK_AXIS;
            qra_pkg::BK_AXIS:
                if (mul_done && mul_last)
                    state_next = qra_pkg::BK_HAM;
            qra_pkg::BK_HAM:
                if (mul_done && mul_last)
                    state_next = qra_pkg::BK_SQ;
            qra_pkg::BK_SQ:
                if (mul_done && mul_last)
                    state_next = qra_pkg::BK_SQRT;
            qra_pkg::BK_SQRT:
                if (cnt_reg == 6'd31)
                    state_next = qra_pkg::BK_NORM;
            qra_pkg::BK_NORM:
                state_next = (rr_reg == 64'd0) ? qra_pkg::BK_MAT : qra_pkg::BK_DIV_SETUP;
            qra_pkg::BK_DIV_SETUP:
                state_next = qra_pkg::BK_DIV;
            qra_pkg::BK_DIV:
                if (cnt_reg == 6'd63)
                    state_next = qra_pkg::BK_DIV_END;
            qra_pkg::BK_DIV_END:
                state_next = (k_reg == 4'd3) ? qra_pkg::BK_MAT : qra_pkg::BK_DIV_SETUP;
            qra_pkg::BK_MAT:
                if (mul_done && mul_last)
                    state_next = qra_pkg::BK_OUT;
            qra_pkg::BK_OUT:
                if (can_load)
                    state_next = qra_pkg::BK_IDLE;
            default:
                state_next = qra_pkg::BK_IDLE;
        endcase
    end

    // outputs: queue pop and multiplier requests
    always_comb
    begin
        q_pop         = 1'b0;
        mul_req.start = 1'b0;
        mul_req.op_a  = 64'sd0;
        mul_req.op_b  = 64'sd0;
        case (state_reg)
            qra_pkg::BK_IDLE:
                q_pop = q_nonempty;
            qra_pkg::BK_AXIS:
            begin
                mul_req.start = !wait_reg;
                mul_req.op_a  = 64'(y_reg);
                mul_req.op_b  = 64'(axis_sel);
            end
            qra_pkg::BK_HAM:
            begin
                mul_req.start = !wait_reg;
                mul_req.op_a  = a_reg[he.a];
                mul_req.op_b  = 64'(orient_reg[he.b]) <<< SCALE_SH;
            end
            qra_pkg::BK_SQ:
            begin
                mul_req.start = !wait_reg;
                mul_req.op_a  = sq_t;
                mul_req.op_b  = sq_t;
            end
            qra_pkg::BK_MAT:
            begin
                mul_req.start = !wait_reg;
                mul_req.op_a  = 64'(orient_reg[mp[3:2]]);
                mul_req.op_b  = 64'(orient_reg[mp[1:0]]);
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= qra_pkg::BK_IDLE;
            cnt_reg          <= 6'd0;
            k_reg            <= 4'd0;
            wait_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
            orient_reg[0]    <= ONE_FIX;
            orient_reg[1]    <= 16'sd0;
            orient_reg[2]    <= 16'sd0;
            orient_reg[3]    <= 16'sd0;
        end
        else
        begin
            state_reg <= state_next;

            if (mul_req.start)
                wait_reg <= 1'b1;
            else if (mul_done)
                wait_reg <= 1'b0;

            if (state_reg == qra_pkg::BK_OUT && can_load)
                result_valid_reg <= 1'b1;
            else if (!result_stall)
                result_valid_reg <= 1'b0;

            case (state_reg)
                qra_pkg::BK_CORDIC:
                    cnt_reg <= cordic_last ? 6'd0 : cnt_reg + 6'd1;
                qra_pkg::BK_SQRT:
                    cnt_reg <= (cnt_reg == 6'd31) ? 6'd0 : cnt_reg + 6'd1;
                qra_pkg::BK_DIV:
                    cnt_reg <= cnt_reg + 6'd1;
                default:
                    cnt_reg <= 6'd0;
            endcase

            case (state_reg)
                qra_pkg::BK_AXIS, qra_pkg::BK_HAM, qra_pkg::BK_SQ, qra_pkg::BK_MAT:
                    if (mul_done)
                        k_reg <= mul_last ? 4'd0 : k_reg + 4'd1;
                qra_pkg::BK_DIV_SETUP, qra_pkg::BK_DIV:
                    k_reg <= k_reg;
                qra_pkg::BK_DIV_END:
                    k_reg <= (k_reg == 4'd3) ? 4'd0 : k_reg + 4'd1;
                default:
                    k_reg <= 4'd0;
            endcase

            if (state_reg == qra_pkg::BK_NORM && rr_reg == 64'd0)
            begin
                orient_reg[0] <= ONE_FIX;
                orient_reg[1] <= 16'sd0;
                orient_reg[2] <= 16'sd0;
                orient_reg[3] <= 16'sd0;
            end
            else if (state_reg == qra_pkg::BK_DIV_END)
            begin
                orient_reg[k_reg[1:0]] <= qra_pkg::sat16(vv);
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            qra_pkg::BK_IDLE:
                if (q_nonempty)
                begin
                    work_reg  <= q_data;
                    x_reg     <= CW'(qra_pkg::GAIN_Q30);
                    y_reg     <= '0;
                    z_reg     <= CW'(q_data.half_angle);
                    for (int i = 0; i < 4; i++)
                        c_reg[i] <= 64'sd0;
                    rx_reg    <= 64'd0;
                    rr_reg    <= 64'd0;
                    degen_reg <= 1'b0;
                end
            qra_pkg::BK_CORDIC:
            begin
                // half angles past a quarter turn were folded; negate cos and sin
                x_reg <= (cordic_last && work_reg.flip) ? -nx : nx;
                y_reg <= (cordic_last && work_reg.flip) ? -ny : ny;
                z_reg <= nz;
            end
            qra_pkg::BK_AXIS:
            begin
                a_reg[0] <= 64'(x_reg);
                if (mul_done)
                    a_reg[k_reg[1:0] + 2'd1] <= qra_pkg::rnd64(prod, 14);
            end
            qra_pkg::BK_HAM:
                if (mul_done)
                begin
                    if (he.neg)
                        c_reg[he.c] <= c_reg[he.c] - qra_pkg::rnd64(prod, 30);
                    else
                        c_reg[he.c] <= c_reg[he.c] + qra_pkg::rnd64(prod, 30);
                end
            qra_pkg::BK_SQ:
                if (mul_done)
                    rx_reg <= rx_reg + prod;
            qra_pkg::BK_SQRT:
                if (sq_ge)
                begin
                    rx_reg <= rx_reg - sq_sum;
                    rr_reg <= (rr_reg >> 1) + bitv;
                end
                else
                begin
                    rr_reg <= rr_reg >> 1;
                end
            qra_pkg::BK_NORM:
                if (rr_reg == 64'd0)
                    degen_reg <= 1'b1;
            qra_pkg::BK_DIV_SETUP:
            begin
                divd_reg   <= unum;
                rem_reg    <= 34'd0;
                numneg_reg <= num[63];
                cneg_reg   <= ck[63];
            end
            qra_pkg::BK_DIV:
            begin
                divd_reg <= {divd_reg[62:0], tge};
                rem_reg  <= tge ? diff[33:0] : trial[33:0];
            end
            qra_pkg::BK_MAT:
                if (mul_done)
                    p_reg[k_reg] <= prod[31:0];
            qra_pkg::BK_OUT:
                if (can_load)
                    result_reg <= mat_w;
            default:
                rem_reg <= rem_reg;
        endcase
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

@@ verif/quaternion_rotation_accumulator_unit_tb.sv @@
// Self-checking testbench for quaternion_rotation_accumulator_unit: directed table then
// random axis/angle transactions, each result checked against an internal fixed-point model or a written-out matrix.
// Depends on qra_pkg and the RTL of the unit.
module quaternion_rotation_accumulator_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STEPS     = 16;
    localparam int FB        = 14;
    localparam int WORK      = 30;
    localparam int N_RANDOM  = 1630;
    localparam int STALL_MAX = 20000;   // cycles with no transaction before giving up
    localparam int DRAIN     = 600;     // idle cycles run after the last expected result

    localparam logic signed [63:0] PI_W      = 64'sd3373259426;
    localparam logic signed [63:0] HALF_PI_W = 64'sd1686629713;
    localparam logic signed [63:0] GAIN_W    = 64'sd652032874;
    localparam logic signed [63:0] ARCTAN [24] = '{
        64'sd843314857, 64'sd497837829, 64'sd263043837, 64'sd133525159,
        64'sd67021687, 64'sd33543516, 64'sd16775851, 64'sd8388437,
        64'sd4194283, 64'sd2097149, 64'sd1048576, 64'sd524288,
        64'sd262144, 64'sd131072, 64'sd65536, 64'sd32768,
        64'sd16384, 64'sd8192, 64'sd4096, 64'sd2048,
        64'sd1024, 64'sd512, 64'sd256, 64'sd128
    };

    typedef struct {
        qra_pkg::in_t  v;
        bit            typed;     // expected matrix written out below
        qra_pkg::out_t mat;
    } row_t;

    logic          clk;
    logic          rst_n;
    logic          item_valid;
    logic          item_stall;
    qra_pkg::in_t  item;
    logic          result_valid;
    logic          result_stall;
    qra_pkg::out_t result;

    // Side info for the transaction being offered, changes with the payload.
    bit            cur_typed;
    qra_pkg::out_t cur_mat;

    logic signed [15:0] orient [4];     // model copy of (w, x, y, z)
    qra_pkg::out_t matrix_q [$];        // expected matrices, oldest first
    bit   idling;
    int   n_bad;
    int   n_items;
    int   n_results;
    int   n_degen;
    int   quiet;

    quaternion_rotation_accumulator_unit #(
        .CORDIC_STEPS(STEPS),
        .FRAC_BITS(FB)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item(item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic signed [63:0] round_sh(logic signed [63:0] v, int s);
        if (s == 0)
            return v;
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic logic signed [15:0] clip16(logic signed [63:0] v);
        if (v > 64'sd32767)
            return 16'sh7fff;
        if (v < -64'sd32768)
            return 16'sh8000;
        return v[15:0];
    endfunction

    function automatic logic [63:0] floor_root(logic [63:0] xv);
        logic [63:0] r;
        logic [63:0] bt;
        r = 64'd0;
        bt = 64'd1 << 62;
        while (bt > xv)
            bt = bt >> 2;
        while (bt != 64'd0)
        begin
            if (xv >= r + bt)
            begin
                xv = xv - (r + bt);
                r = (r >> 1) + bt;
            end
            else
                r = r >> 1;
            bt = bt >> 2;
        end
        return r;
    endfunction

    function automatic logic signed [63:0] mulw(logic signed [63:0] p, logic signed [63:0] q);
        return round_sh(p * q, WORK);
    endfunction

    function automatic void orient_identity();
        orient[0] = clip16(64'sd1 <<< FB);
        orient[1] = '0;
        orient[2] = '0;
        orient[3] = '0;
    endfunction

    // Rotate the stored orientation by one axis/angle pair, return its matrix.
    function automatic qra_pkg::out_t rotate_orientation(qra_pkg::in_t v);
        logic signed [63:0] h, cx, sy, nx, t, n30, mag, q, one2, w, x, y, z;
        logic signed [63:0] qa [4];
        logic signed [63:0] qb [4];
        logic signed [63:0] qc [4];
        logic signed [63:0] mv [9];
        logic signed [63:0] ax [3];
        logic [63:0] ss, n28;
        logic signed [15:0] e [9];
        bit flip;
        bit degen;
        int n;
        qra_pkg::out_t r;
        flip = 1'b0;
        degen = 1'b0;
        h = v.angle;
        h = h <<< 17;
        if (h > HALF_PI_W)
        begin
            h = h - PI_W;
            flip = 1'b1;
        end
        else if (h < -HALF_PI_W)
        begin
            h = h + PI_W;
            flip = 1'b1;
        end
        cx = GAIN_W;
        sy = 0;
        n = STEPS > 24 ? 24 : STEPS;
        for (int i = 0; i < n; i++)
        begin
            if (h >= 0)
            begin
                nx = cx - (sy >>> i);
                sy = sy + (cx >>> i);
                h = h - ARCTAN[i];
            end
            else
            begin
                nx = cx + (sy >>> i);
                sy = sy - (cx >>> i);
                h = h + ARCTAN[i];
            end
            cx = nx;
        end
        if (flip)
        begin
            cx = -cx;
            sy = -sy;
        end
        ax[0] = v.axis_x;
        ax[1] = v.axis_y;
        ax[2] = v.axis_z;
        qa[0] = cx;
        for (int k = 0; k < 3; k++)
            qa[k + 1] = round_sh(sy * ax[k], 14);
        for (int k = 0; k < 4; k++)
        begin
            qb[k] = orient[k];
            qb[k] = qb[k] <<< (WORK - FB);
        end
        // Hamilton product, new times old
        qc[0] = mulw(qa[0], qb[0]) - mulw(qa[1], qb[1]) - mulw(qa[2], qb[2])
              - mulw(qa[3], qb[3]);
        qc[1] = mulw(qa[0], qb[1]) + mulw(qb[0], qa[1]) + mulw(qa[2], qb[3])
              - mulw(qa[3], qb[2]);
        qc[2] = mulw(qa[0], qb[2]) + mulw(qb[0], qa[2]) + mulw(qa[3], qb[1])
              - mulw(qa[1], qb[3]);
        qc[3] = mulw(qa[0], qb[3]) + mulw(qb[0], qa[3]) + mulw(qa[1], qb[2])
              - mulw(qa[2], qb[1]);
        ss = 64'd0;
        for (int k = 0; k < 4; k++)
        begin
            t = qc[k] >>> 2;
            ss = ss + 64'(t * t);     // wraps like the 64-bit datapath
        end
        n28 = floor_root(ss);
        if (n28 == 64'd0)
        begin
            orient_identity();
            degen = 1'b1;
        end
        else
        begin
            n30 = $signed(n28) * 4;
            for (int k = 0; k < 4; k++)
            begin
                mag = qc[k] < 0 ? -qc[k] : qc[k];
                q = (mag * (64'sd1 <<< FB) + n30 / 2) / n30;
                orient[k] = clip16(qc[k] < 0 ? -q : q);
            end
        end
        w = orient[0];
        x = orient[1];
        y = orient[2];
        z = orient[3];
        one2 = 64'sd1 <<< (2 * FB);
        mv[0] = one2 - 2 * (y * y + z * z);
        mv[1] = 2 * (x * y - z * w);
        mv[2] = 2 * (x * z + y * w);
        mv[3] = 2 * (x * y + z * w);
        mv[4] = one2 - 2 * (x * x + z * z);
        mv[5] = 2 * (y * z - x * w);
        mv[6] = 2 * (x * z - y * w);
        mv[7] = 2 * (y * z + x * w);
        mv[8] = one2 - 2 * (x * x + y * y);
        for (int k = 0; k < 9; k++)
            e[k] = clip16(round_sh(mv[k], FB));
        r.m00 = e[0];
        r.m01 = e[1];
        r.m02 = e[2];
        r.m10 = e[3];
        r.m11 = e[4];
        r.m12 = e[5];
        r.m20 = e[6];
        r.m21 = e[7];
        r.m22 = e[8];
        r.degenerate = degen;
        return r;
    endfunction

    // Predict at every accepted input transaction. The model always advances; rows with a
    // written-out matrix queue that one instead.
    always @(posedge clk)
    begin
        qra_pkg::out_t p;
        if (rst_n && item_valid && !item_stall)
        begin
            p = rotate_orientation(item);
            matrix_q.push_back(cur_typed ? cur_mat : p);
            n_items++;
            quiet = 0;
        end
        else if (rst_n && result_valid && !result_stall)
            quiet = 0;
        else if (rst_n)
        begin
            quiet++;
            if (quiet >= STALL_MAX)
            begin
                $display("timeout: no transaction for %0d cycles, %0d results pending",
                         quiet, matrix_q.size());
                $display("quaternion_rotation_accumulator_unit_tb: FAIL");
                $finish;
            end
        end
    end

    // Check every accepted result, field by field, against the oldest expectation.
    always @(posedge clk)
    begin
        qra_pkg::out_t x;
        logic [15:0] ev [10];
        logic [15:0] gv [10];
        bit bad;
        if (rst_n && result_valid && !result_stall)
        begin
            n_results++;
            if (matrix_q.size() == 0)
            begin
                n_bad++;
                if (n_bad <= 10)
                    $display("%0t: unexpected result %p", $realtime, result);
            end
            else
            begin
                x = matrix_q.pop_front();
                if (x.degenerate)
                    n_degen++;
                ev = '{x.m00, x.m01, x.m02, x.m10, x.m11, x.m12, x.m20, x.m21, x.m22,
                       {15'd0, x.degenerate}};
                gv = '{result.m00, result.m01, result.m02, result.m10, result.m11,
                       result.m12, result.m20, result.m21, result.m22,
                       {15'd0, result.degenerate}};
                bad = 1'b0;
                for (int k = 0; k < 10; k++)
                begin
                    if (gv[k] !== ev[k])
                        bad = 1'b1;
                end
                if (bad)
                begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("%0t: result %0d mismatch\n  exp %p\n  got %p",
                                 $realtime, n_results, x, result);
                end
            end
        end
    end

    // Result side: while idling, stall a random number of cycles ahead of each transaction.
    initial
    begin
        int n;
        result_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            n = idling ? $urandom_range(0, 15) : 0;
            if (n > 0)
            begin
                result_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            result_stall <= 1'b0;
            do
                @(posedge clk);
            while (!(result_valid && !result_stall));
        end
    end

    // Offer one transaction and return at the edge where it is taken.
    task automatic offer_rotation(qra_pkg::in_t v, bit typed, qra_pkg::out_t mat);
        int gap;
        gap = idling ? $urandom_range(0, 15) : 0;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item <= v;
        cur_typed <= typed;
        cur_mat <= mat;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (!(item_valid && !item_stall));
    endtask

    function automatic logic signed [15:0] rand_field(int mode);
        case (mode)
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return '0;
            default: return 16'($urandom());
        endcase
    endfunction

    initial
    begin
        row_t table_rows [$];
        row_t rw;
        qra_pkg::out_t ident;
        qra_pkg::out_t none;
        qra_pkg::in_t  v;
        int   kind;

        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        cur_typed = 1'b0;
        cur_mat = '0;
        idling = 1'b1;
        n_bad = 0;
        n_items = 0;
        n_results = 0;
        n_degen = 0;
        quiet = 0;
        orient_identity();

        ident = '{m00: 16'sd16384, m01: '0, m02: '0, m10: '0, m11: 16'sd16384,
                  m12: '0, m20: '0, m21: '0, m22: 16'sd16384, degenerate: 1'b0};
        none = '0;

        // Zero rotation from reset gives the identity matrix.
        table_rows.push_back('{'{16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, ident});
        table_rows.push_back('{'{16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, ident});
        // Unit axes at quarter and half turns, both signs.
        table_rows.push_back('{'{16'sd16384, 16'sd0, 16'sd0, 16'sd6434}, 1'b0, none});
        table_rows.push_back('{'{16'sd0, 16'sd16384, 16'sd0, -16'sd6434}, 1'b0, none});
        table_rows.push_back('{'{16'sd0, 16'sd0, 16'sd16384, 16'sd12868}, 1'b0, none});
        table_rows.push_back('{'{16'sd0, 16'sd0, -16'sd16384, -16'sd12868}, 1'b0, none});
        // Half angle just past a quarter turn: wraps and negates cos/sin.
        table_rows.push_back('{'{16'sd16384, 16'sd0, 16'sd0, 16'sd12870}, 1'b0, none});
        table_rows.push_back('{'{16'sd0, 16'sd16384, 16'sd0, -16'sd12870}, 1'b0, none});
        // Field extremes and non-unit axes.
        table_rows.push_back('{'{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff}, 1'b0, none});
        table_rows.push_back('{'{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000}, 1'b0, none});
        table_rows.push_back('{'{16'sh7fff, 16'sh8000, 16'sd0, 16'sd100}, 1'b0, none});
        table_rows.push_back('{'{16'sd1, -16'sd1, 16'sd1, -16'sd1}, 1'b0, none});
        // Zero axis with angle near +-pi (product close to zero norm), then at the angle extremes.
        table_rows.push_back('{'{16'sd0, 16'sd0, 16'sd0, 16'sd12868}, 1'b0, none});
        table_rows.push_back('{'{16'sd0, 16'sd0, 16'sd0, -16'sd12868}, 1'b0, none});
        table_rows.push_back('{'{16'sd0, 16'sd0, 16'sd0, 16'sh7fff}, 1'b0, none});
        table_rows.push_back('{'{16'sd0, 16'sd0, 16'sd0, 16'sh8000}, 1'b0, none});

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (table_rows[i])
        begin
            rw = table_rows[i];
            offer_rotation(rw.v, rw.typed, rw.mat);
        end

        for (int i = 0; i < N_RANDOM; i++)
        begin
            // A stretch with no idling on either side.
            idling = !(i >= 300 && i < 450);
            // Let the block drain completely once, mid-run.
            if (i == 800)
            begin
                item_valid <= 1'b0;
                do
                    @(posedge clk);
                while (matrix_q.size() != 0);
            end
            kind = $urandom_range(0, 9);
            if (kind < 6)
            begin
                // Mostly plausible rotations: axis components within +-1, angle within +-2pi.
                v.axis_x = 16'($signed($urandom_range(0, 32768)) - 16384);
                v.axis_y = 16'($signed($urandom_range(0, 32768)) - 16384);
                v.axis_z = 16'($signed($urandom_range(0, 32768)) - 16384);
                v.angle  = 16'($signed($urandom_range(0, 51472)) - 25736);
            end
            else if (kind < 8)
            begin
                v.axis_x = rand_field($urandom_range(0, 5));
                v.axis_y = rand_field($urandom_range(0, 5));
                v.axis_z = rand_field($urandom_range(0, 5));
                v.angle  = rand_field($urandom_range(0, 5));
            end
            else
                v = qra_pkg::in_t'({$urandom(), $urandom()});
            offer_rotation(v, 1'b0, none);
        end
        item_valid <= 1'b0;

        do
            @(posedge clk);
        while (matrix_q.size() != 0);
        repeat (DRAIN) @(posedge clk);

        $display("covered %0d rotations (table and random, with stalls and one full drain)",
                 n_items);
        $display("%0d results checked, %0d degenerate, %0d mismatches",
                 n_results, n_degen, n_bad);
        if (n_bad == 0 && matrix_q.size() == 0)
            $display("quaternion_rotation_accumulator_unit_tb: PASS");
        else
            $display("quaternion_rotation_accumulator_unit_tb: FAIL");
        $finish;
    end

endmodule
